FILE: rtl/core/tsge_pkg.sv
// Shared types and constants of the touch scroll gesture engine.
package tsge_pkg;

    localparam int GLIDE_W = 19;   // signed Q10.8 glide velocity
    localparam int MOVE_W  = 10;   // signed move component
    localparam int POS_W   = 15;   // unsigned position
    localparam int CFG_W   = 17;   // widest configuration register

    typedef enum logic [2:0] {
        OP_SLOT  = 3'd0,
        OP_TRACK = 3'd1,
        OP_X     = 3'd2,
        OP_Y     = 3'd3,
        OP_OTHER = 3'd4,
        OP_KEY   = 3'd5,
        OP_TICK  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ACT_DOWN = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_UP   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PENDING = 2'd1,
        MODE_SCROLL  = 2'd2,
        MODE_GLIDE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_VTH      = 3'd0,
        CFG_HTH      = 3'd1,
        CFG_MAXSTEP  = 3'd2,
        CFG_TIMEOUT  = 3'd3,
        CFG_COOLDOWN = 3'd4,
        CFG_INTERVAL = 3'd5,
        CFG_DECAY    = 3'd6,
        CFG_MINSPEED = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVENT,
        ST_EVAL,
        ST_SUM,
        ST_DIV,
        ST_DIVEND,
        ST_SQ_LIFT,
        ST_CMP_LIFT,
        ST_MUL,
        ST_DECAY,
        ST_SQ_GLIDE,
        ST_CMP_GLIDE,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_action                   action;
        logic signed [MOVE_W-1:0]  mx;
        logic signed [MOVE_W-1:0]  my;
    } t_res;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic event_go;
        logic eval;
        logic sum;
        logic div;
        logic div_end;
        logic mul;
        logic decay_end;
        logic sq;
        logic lift_fin;
        logic glide_fin;
        logic pop;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_lift;
        logic need_decay;
        logic div_last;
        logic res_pending;
    } t_dp_st;

endpackage

FILE: rtl/core/tsge_in_if.sv
// Input event channel: opcode and value.
interface tsge_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [15:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

FILE: rtl/core/tsge_out_if.sv
// Result channel: action, move components and last marker.
interface tsge_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic signed [9:0] move_x;
    logic signed [9:0] move_y;
    logic              last;

    modport source (output valid, output action, output move_x, output move_y,
                    output last, input ready);
    modport sink   (input valid, input action, input move_x, input move_y,
                    input last, output ready);
endinterface

FILE: rtl/core/touch_scroll_gesture_engine_unit.sv
// Touch scroll gesture engine top level: sequencer, datapath and channel ports.
//
// Takes one event beat at a time and returns its zero, one or two result beats
// before taking the next. A plain event steps through accept, update, motion
// check and drain; the drain holds while the receiver stalls. A lift of finger 0
// while scrolling replaces the motion check with the velocity average: a load
// step, the bit-serial divider at one quotient bit per cycle (20 bits with 5
// samples), then loading the average and the squared speed compare. A tick
// that triggers a momentum decay step instead runs the decay multiply and
// speed compare. No clearing pass after reset. Configuration must be written
// only while no event is in flight; the block itself does not enforce this.
module touch_scroll_gesture_engine_unit
    import tsge_pkg::*;
#(
    parameter int FINGER_SLOTS = 8,
    parameter int VEL_SAMPLES  = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    tsge_in_if.sink          i_in,
    tsge_out_if.source       o_out
);

    t_dp_cmd cmd;
    t_dp_st  st;
    t_res    res;
    logic    res_last;

    // sequencer
    tsge_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    // datapath
    tsge_dp #(
        .FINGER_SLOTS (FINGER_SLOTS),
        .VEL_SAMPLES  (VEL_SAMPLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_opcode   (i_in.opcode),
        .i_value    (i_in.value),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_res      (res),
        .o_last     (res_last)
    );

    // result beat payload
    assign o_out.action = res.action;
    assign o_out.move_x = res.mx;
    assign o_out.move_y = res.my;
    assign o_out.last   = res_last;

endmodule

FILE: rtl/core/tsge_ctrl.sv
// Sequencer of the gesture engine: steps one event through the datapath.
module tsge_ctrl
    import tsge_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_st  i_st,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVENT;
                end
            end
            ST_EVENT: begin
                o_cmd.event_go = 1'b1;
                if (i_st.need_lift) begin
                    n_state = ST_SUM;
                end else if (i_st.need_decay) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_OUT;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_st.div_last) begin
                    n_state = ST_DIVEND;
                end
            end
            ST_DIVEND: begin
                o_cmd.div_end = 1'b1;
                n_state       = ST_SQ_LIFT;
            end
            ST_SQ_LIFT: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_CMP_LIFT;
            end
            ST_CMP_LIFT: begin
                o_cmd.lift_fin = 1'b1;
                n_state        = ST_OUT;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DECAY;
            end
            ST_DECAY: begin
                o_cmd.decay_end = 1'b1;
                n_state         = ST_SQ_GLIDE;
            end
            ST_SQ_GLIDE: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_CMP_GLIDE;
            end
            ST_CMP_GLIDE: begin
                o_cmd.glide_fin = 1'b1;
                n_state         = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = i_st.res_pending;
                o_cmd.pop   = i_st.res_pending && i_out_ready;
                if (!i_st.res_pending) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // input and output beats never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input and output both open");

    // an accepted beat is always processed next cycle
    a_accept_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_EVENT))
        else $error("accepted beat not processed");

endmodule

FILE: rtl/core/tsge_dp.sv
// Datapath of the gesture engine: gesture state, divider, multiplier, result buffer.
module tsge_dp
    import tsge_pkg::*;
#(
    parameter int FINGER_SLOTS = 8,
    parameter int VEL_SAMPLES  = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [2:0]         i_opcode,
    input  logic signed [15:0] i_value,
    input  t_dp_cmd            i_cmd,
    output t_dp_st             o_st,
    output t_res               o_res,
    output logic               o_last
);

    localparam int RPW  = (VEL_SAMPLES > 1) ? $clog2(VEL_SAMPLES) : 1;
    localparam int FLW  = $clog2(VEL_SAMPLES + 1);
    localparam int SUMW = MOVE_W + FLW;
    localparam int DVW  = SUMW - 1 + 8;
    localparam int DCW  = $clog2(DVW + 1);

    // configuration
    logic [14:0] r_vth, r_hth;
    logic [8:0]  r_max_step;
    logic [15:0] r_timeout, r_cooldown;
    logic [7:0]  r_interval;
    logic [15:0] r_decay;
    logic [16:0] r_min_speed;

    // latched event
    logic [2:0]         r_op;
    logic signed [15:0] r_val;

    // gesture state
    t_mode                    r_mode, n_mode;
    logic [3:0]               r_slot, n_slot;
    logic                     r_slot_inv, n_slot_inv;
    logic [FINGER_SLOTS-1:0]  r_finger, n_finger;
    logic [POS_W-1:0]         r_first_x, n_first_x, r_first_y, n_first_y;
    logic [POS_W-1:0]         r_start_x, n_start_x, r_start_y, n_start_y;
    logic [POS_W-1:0]         r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic signed [MOVE_W-1:0] r_ring_x [VEL_SAMPLES];
    logic signed [MOVE_W-1:0] n_ring_x [VEL_SAMPLES];
    logic signed [MOVE_W-1:0] r_ring_y [VEL_SAMPLES];
    logic signed [MOVE_W-1:0] n_ring_y [VEL_SAMPLES];
    logic [RPW-1:0]           r_ring_pos, n_ring_pos;
    logic [FLW-1:0]           r_ring_fill, n_ring_fill;
    logic signed [GLIDE_W-1:0] r_gvx, n_gvx, r_gvy, n_gvy;
    logic                     r_held, n_held;
    logic [15:0]              r_key_age, n_key_age, r_gest_age, n_gest_age;
    logic [7:0]               r_ic, n_ic;

    // divider, multiplier and compare pipeline
    logic [DVW-1:0]     r_dq_x, r_dq_y;
    logic [FLW:0]       r_rem_x, r_rem_y;
    logic               r_neg_x, r_neg_y;
    logic [DCW-1:0]     r_div_cnt;
    logic [GLIDE_W+15:0] r_prod_x, r_prod_y;
    logic [2*GLIDE_W-1:0] r_sq_x, r_sq_y;
    logic [33:0]        r_flsq;

    // result buffer
    t_res       r_res [2];
    t_res       n_res [2];
    logic [1:0] r_res_cnt, n_res_cnt;
    logic       r_rd_idx, n_rd_idx;

    // decode helpers
    logic        typing, is_touch, slot0, val_neg, slot_in_range, glide_or_scroll;
    logic [7:0]  iv, ic_inc;
    logic [POS_W-1:0] pos_p;
    assign typing          = r_key_age < r_cooldown;
    assign is_touch        = r_op <= OP_OTHER;
    assign slot0           = (r_slot == 4'd0);
    assign val_neg         = r_val[15];
    assign slot_in_range   = !val_neg && (r_val[14:0] < 15'(FINGER_SLOTS));
    assign glide_or_scroll = (r_mode == MODE_SCROLL) || (r_mode == MODE_GLIDE);
    assign iv              = (r_interval == 8'd0) ? 8'd1 : r_interval;
    assign ic_inc          = r_ic + 8'd1;
    assign pos_p           = val_neg ? '0 : r_val[14:0];

    // displacement for motion evaluation
    logic [POS_W-1:0]  ref_x, ref_y;
    logic signed [15:0] dx_s, dy_s;
    logic [15:0]       ax, ay;
    logic              thr_hit;
    logic signed [MOVE_W-1:0] cx, cy;
    assign ref_x   = (r_mode == MODE_PENDING) ? r_start_x : r_prev_x;
    assign ref_y   = (r_mode == MODE_PENDING) ? r_start_y : r_prev_y;
    assign dx_s    = $signed({1'b0, r_first_x}) - $signed({1'b0, ref_x});
    assign dy_s    = $signed({1'b0, r_first_y}) - $signed({1'b0, ref_y});
    assign ax      = dx_s[15] ? 16'(-dx_s) : 16'(dx_s);
    assign ay      = dy_s[15] ? 16'(-dy_s) : 16'(dy_s);
    assign thr_hit = (ay > {1'b0, r_vth}) || (ax > {1'b0, r_hth});

    function automatic logic signed [MOVE_W-1:0] clamp_step(
        input logic signed [15:0] d, input logic [8:0] m);
        logic signed [15:0] ms;
        ms = $signed({7'd0, m});
        if (d > ms) begin
            return $signed({1'b0, m});
        end else if (d < -ms) begin
            return -$signed({1'b0, m});
        end
        return d[MOVE_W-1:0];
    endfunction

    assign cx = clamp_step(dx_s, r_max_step);
    assign cy = clamp_step(dy_s, r_max_step);

    // ring sums over filled entries
    logic signed [SUMW-1:0] sum_x, sum_y;
    logic [SUMW-1:0]        smag_x, smag_y;
    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int i = 0; i < VEL_SAMPLES; i++) begin
            if (FLW'(i) < r_ring_fill) begin
                sum_x = sum_x + SUMW'(r_ring_x[i]);
                sum_y = sum_y + SUMW'(r_ring_y[i]);
            end
        end
    end
    assign smag_x = sum_x[SUMW-1] ? SUMW'(-sum_x) : SUMW'(sum_x);
    assign smag_y = sum_y[SUMW-1] ? SUMW'(-sum_y) : SUMW'(sum_y);

    // one restoring division step per cycle
    logic [FLW:0] rem_sh_x, rem_sh_y, rem_nx_x, rem_nx_y;
    logic         ge_x, ge_y;
    assign rem_sh_x = {r_rem_x[FLW-1:0], r_dq_x[DVW-1]};
    assign rem_sh_y = {r_rem_y[FLW-1:0], r_dq_y[DVW-1]};
    assign ge_x     = rem_sh_x >= {1'b0, r_ring_fill};
    assign ge_y     = rem_sh_y >= {1'b0, r_ring_fill};
    assign rem_nx_x = ge_x ? rem_sh_x - {1'b0, r_ring_fill} : rem_sh_x;
    assign rem_nx_y = ge_y ? rem_sh_y - {1'b0, r_ring_fill} : rem_sh_y;

    // quotient to glide velocity
    logic [DVW+GLIDE_W-1:0] qx_x, qx_y;
    logic signed [GLIDE_W-1:0] qm_x, qm_y, avg_x, avg_y;
    assign qx_x  = {{GLIDE_W{1'b0}}, r_dq_x};
    assign qx_y  = {{GLIDE_W{1'b0}}, r_dq_y};
    assign qm_x  = qx_x[GLIDE_W-1:0];
    assign qm_y  = qx_y[GLIDE_W-1:0];
    assign avg_x = (r_ring_fill == '0) ? '0 : (r_neg_x ? -qm_x : qm_x);
    assign avg_y = (r_ring_fill == '0) ? '0 : (r_neg_y ? -qm_y : qm_y);

    // glide magnitudes, decayed velocity, speed compare
    logic [GLIDE_W-1:0] mag_x, mag_y, dmag_x, dmag_y;
    logic signed [GLIDE_W-1:0] dec_x, dec_y;
    logic [2*GLIDE_W:0] ssum;
    logic               slow, fast;
    logic signed [MOVE_W-1:0] gmx, gmy;
    assign mag_x  = r_gvx[GLIDE_W-1] ? GLIDE_W'(-r_gvx) : GLIDE_W'(r_gvx);
    assign mag_y  = r_gvy[GLIDE_W-1] ? GLIDE_W'(-r_gvy) : GLIDE_W'(r_gvy);
    assign dmag_x = r_prod_x[GLIDE_W+15:16];
    assign dmag_y = r_prod_y[GLIDE_W+15:16];
    assign dec_x  = r_gvx[GLIDE_W-1] ? -$signed(dmag_x) : $signed(dmag_x);
    assign dec_y  = r_gvy[GLIDE_W-1] ? -$signed(dmag_y) : $signed(dmag_y);
    assign ssum   = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign slow   = ssum < (2*GLIDE_W+1)'(r_flsq);
    assign fast   = ssum > (2*GLIDE_W+1)'(r_flsq);
    assign gmx    = r_gvx[GLIDE_W-1] ? -$signed(mag_x[17:8]) : $signed(mag_x[17:8]);
    assign gmy    = r_gvy[GLIDE_W-1] ? -$signed(mag_y[17:8]) : $signed(mag_y[17:8]);

    // next gesture state
    logic           cancel, do_move, e_a_v, e_b_v;
    t_res           e_a, e_b;
    logic [RPW-1:0] wpos;
    logic [FLW-1:0] wfill;
    always_comb begin
        n_mode = r_mode;  n_slot = r_slot;  n_slot_inv = r_slot_inv;
        n_finger = r_finger;
        n_first_x = r_first_x;  n_first_y = r_first_y;
        n_start_x = r_start_x;  n_start_y = r_start_y;
        n_prev_x = r_prev_x;    n_prev_y = r_prev_y;
        n_ring_x = r_ring_x;    n_ring_y = r_ring_y;
        n_ring_pos = r_ring_pos; n_ring_fill = r_ring_fill;
        n_gvx = r_gvx;  n_gvy = r_gvy;  n_held = r_held;
        n_key_age = r_key_age;  n_gest_age = r_gest_age;  n_ic = r_ic;
        n_res = r_res;  n_res_cnt = r_res_cnt;  n_rd_idx = r_rd_idx;
        e_a_v = 1'b0;  e_b_v = 1'b0;  e_a = '0;  e_b = '0;
        do_move = 1'b0;  wpos = '0;  wfill = '0;

        // gesture cancel from an event or a slow glide
        cancel = 1'b0;
        if (i_cmd.event_go) begin
            if (is_touch && typing) begin
                cancel = glide_or_scroll;
            end else if (is_touch && r_op == OP_TRACK && !val_neg && !r_slot_inv &&
                         r_mode == MODE_GLIDE) begin
                cancel = 1'b1;
            end else if (r_op == OP_KEY) begin
                cancel = (r_cooldown != 16'd0) && glide_or_scroll;
            end
        end
        if (i_cmd.glide_fin && slow) begin
            cancel = 1'b1;
        end
        if (cancel) begin
            if (r_held) begin
                e_a_v = 1'b1;
                e_a.action = ACT_UP;
            end
            n_held = 1'b0;  n_mode = MODE_IDLE;  n_finger = '0;
            n_first_x = '0; n_first_y = '0; n_start_x = '0; n_start_y = '0;
            for (int i = 0; i < VEL_SAMPLES; i++) begin
                n_ring_x[i] = '0;
                n_ring_y[i] = '0;
            end
            n_ring_pos = '0;  n_ring_fill = '0;
        end

        // event effects
        if (i_cmd.event_go) begin
            if (is_touch) begin
                if (!typing) begin
                    if (r_op == OP_SLOT) begin
                        if (slot_in_range) begin
                            n_slot     = r_val[3:0];
                            n_slot_inv = 1'b0;
                        end else begin
                            n_slot_inv = 1'b1;
                        end
                    end else if (r_op <= OP_Y && !r_slot_inv) begin
                        if (r_op == OP_TRACK) begin
                            for (int i = 0; i < FINGER_SLOTS; i++) begin
                                if (r_slot == 4'(i)) begin
                                    n_finger[i] = !val_neg;
                                end
                            end
                            if (!val_neg && slot0) begin
                                n_first_x = '0; n_first_y = '0;
                                n_start_x = '0; n_start_y = '0;
                                if (n_mode == MODE_IDLE) begin
                                    n_mode     = MODE_PENDING;
                                    n_gest_age = '0;
                                end
                            end
                        end else if (slot0) begin
                            if (r_op == OP_X) begin
                                n_first_x = pos_p;
                                if (r_finger[0] && r_start_x == '0) begin
                                    n_start_x = pos_p;
                                end
                            end else begin
                                n_first_y = pos_p;
                                if (r_finger[0] && r_start_y == '0) begin
                                    n_start_y = pos_p;
                                end
                            end
                        end
                    end
                end
            end else if (r_op == OP_KEY) begin
                n_key_age = '0;
            end else if (r_op == OP_TICK) begin
                if (r_key_age != 16'hFFFF) begin
                    n_key_age = r_key_age + 16'd1;
                end
                if (r_gest_age != 16'hFFFF) begin
                    n_gest_age = r_gest_age + 16'd1;
                end
                if (r_mode == MODE_GLIDE) begin
                    n_ic = (ic_inc >= iv) ? 8'd0 : ic_inc;
                end
                if (r_mode == MODE_PENDING && (!r_finger[0] || n_gest_age > r_timeout)) begin
                    n_mode = MODE_IDLE;  n_finger = '0;
                    n_first_x = '0; n_first_y = '0; n_start_x = '0; n_start_y = '0;
                    for (int i = 0; i < VEL_SAMPLES; i++) begin
                        n_ring_x[i] = '0;
                        n_ring_y[i] = '0;
                    end
                    n_ring_pos = '0;  n_ring_fill = '0;
                end
            end
        end

        // motion evaluation after a touch event
        if (i_cmd.eval && is_touch && !typing &&
            (r_mode == MODE_PENDING || r_mode == MODE_SCROLL) && r_finger[0] &&
            r_start_x != '0 && r_start_y != '0) begin
            if (r_mode == MODE_PENDING) begin
                if (thr_hit) begin
                    n_mode = MODE_SCROLL;
                    n_prev_x = r_first_x;  n_prev_y = r_first_y;
                    for (int i = 0; i < VEL_SAMPLES; i++) begin
                        n_ring_x[i] = '0;
                        n_ring_y[i] = '0;
                    end
                    e_a_v = 1'b1;
                    e_a.action = ACT_DOWN;
                    do_move = 1'b1;
                end else if (r_gest_age > r_timeout) begin
                    n_mode = MODE_IDLE;  n_finger = '0;
                    n_first_x = '0; n_first_y = '0; n_start_x = '0; n_start_y = '0;
                end
            end else begin
                n_prev_x = r_first_x;  n_prev_y = r_first_y;
                wpos  = r_ring_pos;
                wfill = r_ring_fill;
                do_move = 1'b1;
            end
            if (do_move) begin
                n_ring_x[wpos] = cx;
                n_ring_y[wpos] = cy;
                n_ring_pos  = (wpos == RPW'(VEL_SAMPLES - 1)) ? '0 : wpos + RPW'(1);
                n_ring_fill = (wfill < FLW'(VEL_SAMPLES)) ? wfill + FLW'(1) : wfill;
                e_b_v = 1'b1;
                e_b.action = ACT_MOVE;  e_b.mx = cx;  e_b.my = cy;
                n_held = 1'b1;
            end
        end

        // lift of finger 0: average loaded, decide glide or release
        if (i_cmd.div_end) begin
            n_gvx = avg_x;
            n_gvy = avg_y;
        end
        if (i_cmd.lift_fin) begin
            if (fast) begin
                n_mode = MODE_GLIDE;
                n_ic   = '0;
            end else begin
                if (r_held) begin
                    e_a_v = 1'b1;
                    e_a.action = ACT_UP;
                end
                n_held = 1'b0;  n_mode = MODE_IDLE;
                for (int i = 0; i < VEL_SAMPLES; i++) begin
                    n_ring_x[i] = '0;
                    n_ring_y[i] = '0;
                end
                n_ring_pos = '0;  n_ring_fill = '0;
            end
        end

        // one glide decay step
        if (i_cmd.decay_end) begin
            n_gvx = dec_x;
            n_gvy = dec_y;
        end
        if (i_cmd.glide_fin && !slow && (gmx != '0 || gmy != '0)) begin
            e_b_v = 1'b1;
            e_b.action = ACT_MOVE;  e_b.mx = gmx;  e_b.my = gmy;
            n_held = 1'b1;
        end

        // result buffer: pop, then append
        if (i_cmd.pop) begin
            if ({1'b0, r_rd_idx} + 2'd1 == r_res_cnt) begin
                n_res_cnt = '0;
                n_rd_idx  = 1'b0;
            end else begin
                n_rd_idx = 1'b1;
            end
        end
        if (e_a_v && n_res_cnt < 2'd2) begin
            n_res[n_res_cnt[0]] = e_a;
            n_res_cnt = n_res_cnt + 2'd1;
        end
        if (e_b_v && n_res_cnt < 2'd2) begin
            n_res[n_res_cnt[0]] = e_b;
            n_res_cnt = n_res_cnt + 2'd1;
        end
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vth <= 15'd30;  r_hth <= 15'd30;  r_max_step <= 9'd64;
            r_timeout <= 16'd500;  r_cooldown <= 16'd500;  r_interval <= 8'd16;
            r_decay <= 16'd60293;  r_min_speed <= 17'd256;
            r_mode <= MODE_IDLE;  r_slot <= '0;  r_slot_inv <= 1'b0;  r_finger <= '0;
            r_first_x <= '0;  r_first_y <= '0;  r_start_x <= '0;  r_start_y <= '0;
            r_prev_x <= '0;  r_prev_y <= '0;
            for (int i = 0; i < VEL_SAMPLES; i++) begin
                r_ring_x[i] <= '0;
                r_ring_y[i] <= '0;
            end
            r_ring_pos <= '0;  r_ring_fill <= '0;
            r_gvx <= '0;  r_gvy <= '0;  r_held <= 1'b0;
            r_key_age <= 16'hFFFF;  r_gest_age <= '0;  r_ic <= '0;
            r_div_cnt <= '0;  r_res_cnt <= '0;  r_rd_idx <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_VTH:      r_vth       <= i_cfg_data[14:0];
                    CFG_HTH:      r_hth       <= i_cfg_data[14:0];
                    CFG_MAXSTEP:  r_max_step  <= i_cfg_data[8:0];
                    CFG_TIMEOUT:  r_timeout   <= i_cfg_data[15:0];
                    CFG_COOLDOWN: r_cooldown  <= i_cfg_data[15:0];
                    CFG_INTERVAL: r_interval  <= i_cfg_data[7:0];
                    CFG_DECAY:    r_decay     <= i_cfg_data[15:0];
                    CFG_MINSPEED: r_min_speed <= i_cfg_data[16:0];
                endcase
            end
            r_mode <= n_mode;  r_slot <= n_slot;  r_slot_inv <= n_slot_inv;
            r_finger <= n_finger;
            r_first_x <= n_first_x;  r_first_y <= n_first_y;
            r_start_x <= n_start_x;  r_start_y <= n_start_y;
            r_prev_x <= n_prev_x;  r_prev_y <= n_prev_y;
            r_ring_x <= n_ring_x;  r_ring_y <= n_ring_y;
            r_ring_pos <= n_ring_pos;  r_ring_fill <= n_ring_fill;
            r_gvx <= n_gvx;  r_gvy <= n_gvy;  r_held <= n_held;
            r_key_age <= n_key_age;  r_gest_age <= n_gest_age;  r_ic <= n_ic;
            r_res_cnt <= n_res_cnt;  r_rd_idx <= n_rd_idx;
            if (i_cmd.sum) begin
                r_div_cnt <= DCW'(DVW);
            end else if (i_cmd.div) begin
                r_div_cnt <= r_div_cnt - DCW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_val <= i_value;
        end
        if (i_cmd.sum) begin
            r_dq_x  <= {smag_x[SUMW-2:0], 8'd0};
            r_dq_y  <= {smag_y[SUMW-2:0], 8'd0};
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_neg_x <= sum_x[SUMW-1];
            r_neg_y <= sum_y[SUMW-1];
        end else if (i_cmd.div) begin
            r_dq_x  <= {r_dq_x[DVW-2:0], ge_x};
            r_dq_y  <= {r_dq_y[DVW-2:0], ge_y};
            r_rem_x <= rem_nx_x;
            r_rem_y <= rem_nx_y;
        end
        if (i_cmd.mul) begin
            r_prod_x <= mag_x * r_decay;
            r_prod_y <= mag_y * r_decay;
        end
        if (i_cmd.sq) begin
            r_sq_x <= mag_x * mag_x;
            r_sq_y <= mag_y * mag_y;
            r_flsq <= r_min_speed * r_min_speed;
        end
    end

    // status and result port
    assign o_st.need_lift   = (r_op == OP_TRACK) && val_neg && !typing && !r_slot_inv &&
                              slot0 && (r_mode == MODE_SCROLL);
    assign o_st.need_decay  = (r_op == OP_TICK) && (r_mode == MODE_GLIDE) && (ic_inc >= iv);
    assign o_st.div_last    = (r_div_cnt == DCW'(1));
    assign o_st.res_pending = ({1'b0, r_rd_idx} < r_res_cnt);
    assign o_res            = r_res[r_rd_idx];
    assign o_last           = ({1'b0, r_rd_idx} + 2'd1 == r_res_cnt);

    // an active scroll or glide always holds the synthetic touch
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_SCROLL || r_mode == MODE_GLIDE) |-> r_held)
        else $error("scroll or glide without touch held");

    // read pointer stays within the buffered results
    a_rd_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_rd_idx} <= r_res_cnt) else $error("result read past fill");

    // ring pointer and fill stay within the sample depth
    a_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_ring_pos) < VEL_SAMPLES) && (32'(r_ring_fill) <= VEL_SAMPLES))
        else $error("velocity ring out of range");

endmodule

FILE: dv/tsge_scoreboard.sv
// Gesture engine checker: mirrors config writes, predicts result beats, compares them.
module tsge_scoreboard
    import tsge_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    tsge_in_if               in_ch,
    tsge_out_if              out_ch,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_action           action;
        logic signed [9:0] mx;
        logic signed [9:0] my;
        bit                last;
    } t_gesture_res;

    // Mirrored configuration
    int vth, hth, max_step, timeout_ms, cooldown_ms, interval_ms, decay, min_speed;

    // Mirrored engine state
    t_mode   mode;
    int      slot_sel;
    bit      slot_bad;
    bit      finger_on [8];
    int      cur_x, cur_y, start_x, start_y, prev_x, prev_y;
    int      ring_x [5];
    int      ring_y [5];
    int      ring_pos, ring_fill;
    longint  glide_x, glide_y;
    bit      held;
    int      key_age, gesture_age, interval_cnt;

    t_gesture_res step_res [2];
    int           step_n;
    t_gesture_res expected_moves [$];

    assign o_pending = expected_moves.size();

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic void push_res(t_action a, int mx, int my);
        if (step_n < 2) begin
            step_res[step_n].action = a;
            step_res[step_n].mx = mx[9:0];
            step_res[step_n].my = my[9:0];
            step_res[step_n].last = 1'b0;
            step_n++;
        end
    endfunction

    function automatic void clear_fingers();
        foreach (finger_on[i]) finger_on[i] = 1'b0;
        cur_x = 0; cur_y = 0; start_x = 0; start_y = 0;
    endfunction

    function automatic void clear_ring();
        foreach (ring_x[i]) begin
            ring_x[i] = 0;
            ring_y[i] = 0;
        end
        ring_pos = 0;
        ring_fill = 0;
    endfunction

    function automatic void release_touch();
        if (held) begin
            push_res(ACT_UP, 0, 0);
            held = 1'b0;
        end
    endfunction

    function automatic void cancel_gesture();
        release_touch();
        mode = MODE_IDLE;
        clear_fingers();
        clear_ring();
    endfunction

    function automatic int clamp_step(int d);
        if (d > max_step) return max_step;
        if (d < -max_step) return -max_step;
        return d;
    endfunction

    function automatic void scroll_move(int dx, int dy);
        dx = clamp_step(dx);
        dy = clamp_step(dy);
        ring_x[ring_pos] = dx;
        ring_y[ring_pos] = dy;
        ring_pos = (ring_pos + 1) % 5;
        if (ring_fill < 5) ring_fill++;
        push_res(ACT_MOVE, dx, dy);
        held = 1'b1;
    endfunction

    function automatic longint speed_sq();
        return glide_x * glide_x + glide_y * glide_y;
    endfunction

    function automatic longint decay_one(longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag * decay) >>> 16;
        return (v < 0) ? -mag : mag;
    endfunction

    // Lift of finger 0: average the ring, then glide or release
    function automatic void lift_finger0();
        int sx, sy;
        sx = 0; sy = 0;
        if (mode != MODE_SCROLL) return;
        for (int i = 0; i < ring_fill; i++) begin
            sx += ring_x[i];
            sy += ring_y[i];
        end
        glide_x = ring_fill ? (sx * 256) / ring_fill : 0;
        glide_y = ring_fill ? (sy * 256) / ring_fill : 0;
        if (speed_sq() > longint'(min_speed) * min_speed) begin
            mode = MODE_GLIDE;
            interval_cnt = 0;
        end else begin
            release_touch();
            mode = MODE_IDLE;
            clear_ring();
        end
    endfunction

    function automatic void glide_step();
        longint mx, my;
        glide_x = decay_one(glide_x);
        glide_y = decay_one(glide_y);
        if (speed_sq() < longint'(min_speed) * min_speed) begin
            cancel_gesture();
            return;
        end
        mx = glide_x / 256;
        my = glide_y / 256;
        if (mx == 0 && my == 0) return;
        push_res(ACT_MOVE, int'(mx), int'(my));
        held = 1'b1;
    endfunction

    function automatic void evaluate_motion();
        int dx, dy, ax, ay;
        dx = cur_x - start_x;
        dy = cur_y - start_y;
        if (mode == MODE_PENDING) begin
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            if (ay > vth || ax > hth) begin
                mode = MODE_SCROLL;
                prev_x = cur_x;
                prev_y = cur_y;
                clear_ring();
                push_res(ACT_DOWN, 0, 0);
                held = 1'b1;
                scroll_move(dx, dy);
            end else if (gesture_age > timeout_ms) begin
                mode = MODE_IDLE;
                clear_fingers();
            end
            return;
        end
        if (mode != MODE_SCROLL) return;
        scroll_move(cur_x - prev_x, cur_y - prev_y);
        prev_x = cur_x;
        prev_y = cur_y;
    endfunction

    function automatic void touch_event(t_op op, int v);
        int p;
        if (key_age < cooldown_ms) begin
            if (mode == MODE_SCROLL || mode == MODE_GLIDE) cancel_gesture();
            return;
        end
        if (op == OP_SLOT) begin
            if (v >= 0 && v < 8) begin
                slot_sel = v;
                slot_bad = 1'b0;
            end else begin
                slot_bad = 1'b1;
            end
        end else if (op != OP_OTHER && !slot_bad) begin
            if (op == OP_TRACK) begin
                if (v < 0) begin
                    if (slot_sel == 0) lift_finger0();
                    finger_on[slot_sel] = 1'b0;
                end else begin
                    if (mode == MODE_GLIDE) cancel_gesture();
                    finger_on[slot_sel] = 1'b1;
                    if (slot_sel == 0) begin
                        cur_x = 0; cur_y = 0; start_x = 0; start_y = 0;
                        if (mode == MODE_IDLE) begin
                            mode = MODE_PENDING;
                            gesture_age = 0;
                        end
                    end
                end
            end else if (slot_sel == 0) begin
                p = v < 0 ? 0 : v;
                if (op == OP_X) begin
                    cur_x = p;
                    if (finger_on[0] && start_x == 0) start_x = p;
                end else begin
                    cur_y = p;
                    if (finger_on[0] && start_y == 0) start_y = p;
                end
            end
        end
        if ((mode == MODE_PENDING || mode == MODE_SCROLL) && finger_on[0] &&
            start_x != 0 && start_y != 0)
            evaluate_motion();
    endfunction

    function automatic void ms_tick();
        int iv;
        iv = interval_ms ? interval_ms : 1;
        if (key_age < 65535) key_age++;
        if (gesture_age < 65535) gesture_age++;
        if (mode == MODE_GLIDE) begin
            interval_cnt = (interval_cnt + 1) & 8'hFF;
            if (interval_cnt >= iv) begin
                interval_cnt = 0;
                glide_step();
            end
        end
        if (mode == MODE_PENDING && (!finger_on[0] || gesture_age > timeout_ms)) begin
            mode = MODE_IDLE;
            clear_fingers();
            clear_ring();
        end
    endfunction

    function automatic void predict_gesture(t_op op, int v);
        step_n = 0;
        case (op)
            OP_SLOT, OP_TRACK, OP_X, OP_Y, OP_OTHER: touch_event(op, v);
            OP_KEY: begin
                key_age = 0;
                if (0 < cooldown_ms && (mode == MODE_SCROLL || mode == MODE_GLIDE))
                    cancel_gesture();
            end
            OP_TICK: ms_tick();
            default: ;
        endcase
        for (int i = 0; i < step_n; i++) begin
            step_res[i].last = (i == step_n - 1);
            expected_moves.push_back(step_res[i]);
        end
    endfunction

    function automatic void reset_model();
        vth = 30; hth = 30; max_step = 64; timeout_ms = 500; cooldown_ms = 500;
        interval_ms = 16; decay = 60293; min_speed = 256;
        mode = MODE_IDLE; slot_sel = 0; slot_bad = 1'b0;
        clear_fingers();
        prev_x = 0; prev_y = 0;
        clear_ring();
        glide_x = 0; glide_y = 0; held = 1'b0;
        key_age = 65535; gesture_age = 0; interval_cnt = 0;
    endfunction

    // Mirror config, predict on input beats, check result beats
    always @(posedge i_clk) begin
        t_gesture_res want;
        if (!i_rst_n) begin
            reset_model();
            expected_moves.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_VTH:      vth = i_cfg_data[14:0];
                    CFG_HTH:      hth = i_cfg_data[14:0];
                    CFG_MAXSTEP:  max_step = i_cfg_data[8:0];
                    CFG_TIMEOUT:  timeout_ms = i_cfg_data[15:0];
                    CFG_COOLDOWN: cooldown_ms = i_cfg_data[15:0];
                    CFG_INTERVAL: interval_ms = i_cfg_data[7:0];
                    CFG_DECAY:    decay = i_cfg_data[15:0];
                    CFG_MINSPEED: min_speed = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                predict_gesture(t_op'(in_ch.opcode), int'(in_ch.value));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_moves.size() == 0) begin
                    report($sformatf("unexpected beat act=%0d x=%0d y=%0d",
                                     out_ch.action, out_ch.move_x, out_ch.move_y));
                end else begin
                    want = expected_moves.pop_front();
                    if (out_ch.action !== want.action || out_ch.move_x !== want.mx ||
                        out_ch.move_y !== want.my || out_ch.last !== want.last)
                        report($sformatf("got act=%0d x=%0d y=%0d l=%0d want %0d %0d %0d %0d",
                                         out_ch.action, out_ch.move_x, out_ch.move_y,
                                         out_ch.last, want.action, want.mx, want.my,
                                         want.last));
                end
            end
        end
    end
endmodule

FILE: dv/touch_scroll_gesture_engine_unit_tb.sv
// Testbench top: clock, reset, config phases, gesture stimulus and verdict.
module touch_scroll_gesture_engine_unit_tb;
    import tsge_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE = 60;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [2:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    int               fail_count;
    int               pending;
    int               cycles = 0;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               sent = 0;

    tsge_in_if  in_ch ();
    tsge_out_if out_ch ();

    touch_scroll_gesture_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(in_ch), .o_out(out_ch)
    );

    tsge_scoreboard checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch), .out_ch(out_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(posedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // One event beat; valid is only lowered when a gap is taken
    task automatic send_event(input t_op op, input int v);
        bit hit;
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.value <= v[15:0];
        do begin
            @(negedge i_clk);
            hit = in_ch.ready;
            @(posedge i_clk);
        end while (!hit);
        sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_config(input int vt, input int ht, input int ms, input int tmo,
                               input int cd, input int iv, input int dc, input int sp);
        write_reg(CFG_VTH, vt);
        write_reg(CFG_HTH, ht);
        write_reg(CFG_MAXSTEP, ms);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_COOLDOWN, cd);
        write_reg(CFG_INTERVAL, iv);
        write_reg(CFG_DECAY, dc);
        write_reg(CFG_MINSPEED, sp);
    endtask

    // Finger 0 down, a drag, lift, then ticks to let any glide run
    task automatic swipe_gesture();
        int x, y, sx, sy, steps;
        x = $urandom_range(32000, 100);
        y = $urandom_range(32000, 100);
        sx = $urandom_range(160) - 80;
        sy = $urandom_range(160) - 80;
        send_event(OP_SLOT, 0);
        send_event(OP_TRACK, $urandom_range(30000));
        send_event(OP_X, x);
        send_event(OP_Y, y);
        steps = $urandom_range(10, 2);
        for (int i = 0; i < steps; i++) begin
            if ($urandom_range(9) == 0) send_event(OP_OTHER, $urandom_range(65535));
            if ($urandom_range(14) == 0) send_event(OP_TICK, 0);
            x = x + sx + $urandom_range(20) - 10;
            y = y + sy + $urandom_range(20) - 10;
            send_event(OP_X, x);
            send_event(OP_Y, y);
        end
        if ($urandom_range(7) == 0) begin
            // second finger comes and goes
            send_event(OP_SLOT, 1);
            send_event(OP_TRACK, 5);
            send_event(OP_TRACK, -1);
            send_event(OP_SLOT, 0);
        end
        if ($urandom_range(9) == 0) send_event(OP_KEY, 0);
        send_event(OP_TRACK, -1);
        repeat ($urandom_range(60, 5)) send_event(OP_TICK, 0);
    endtask

    task automatic noise_event();
        send_event(t_op'($urandom_range(7)), $urandom_range(65535));
    endtask

    task automatic directed_events();
        send_event(OP_KEY, 0);
        send_event(t_op'(3'd7), 16'h7FFF);
        send_event(OP_SLOT, 15);
        send_event(OP_TRACK, 3);
        send_event(OP_SLOT, -32768);
        send_event(OP_SLOT, 0);
        send_event(OP_TRACK, 32767);
        send_event(OP_X, -5);
        send_event(OP_X, 1000);
        send_event(OP_Y, 1000);
        send_event(OP_OTHER, -1);
        send_event(OP_X, 1200);
        send_event(OP_Y, 900);
        send_event(OP_Y, 32767);
        send_event(OP_OTHER, 0);
        send_event(OP_TRACK, -1);
        repeat (6) send_event(OP_TICK, 0);
        send_event(OP_KEY, -32768);
        send_event(OP_TICK, 0);
    endtask

    initial begin
        int n_phase;
        in_ch.valid <= 1'b0;
        in_ch.opcode <= OP_TICK;
        in_ch.value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: key_age starts saturated, so typing is inactive until the first key event
        directed_events();
        drain_results();
        load_config(30, 30, 64, 500, 20, 16, 60293, 256);
        directed_events();
        drain_results();

        n_phase = 6;
        for (int ph = 0; ph < n_phase; ph++) begin
            case (ph)
                0: load_config(30, 30, 64, 500, 8, 2, 60293, 64);
                1: load_config(0, 32767, 511, 65535, 0, 1, 65535, 0);
                2: load_config(32767, 0, 1, 0, 3, 1, 0, 131071);
                3: load_config(200, 200, 511, 40, 65535, 3, 50000, 300);
                4: load_config(10, 10, 100, 300, 4, 255, 65000, 1);
                default: load_config(40, 20, 32, 200, 5, 4, 58000, 128);
            endcase
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 37 : 56) : 0;
            stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 37 : 56) : 0;
            while (sent < 60 + (ph + 1) * 170) begin
                if ($urandom_range(9) < 7) swipe_gesture();
                else noise_event();
                if (ph == 2 && sent > 500 && sent < 520) begin
                    // hold off until the engine has drained
                    in_ch.valid <= 1'b0;
                    do @(posedge i_clk); while (pending != 0);
                end
            end
            drain_results();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
